// ===== hw/rtl/ppts_pkg.sv =====
// Shared widths, register indexes and types of the point projection pipeline.
package ppts_pkg;

  // Field widths
  localparam int POS_W      = 48;   // world and camera positions
  localparam int DIFF_W     = POS_W + 1;
  localparam int QC_W       = 16;   // one Q1.14 quaternion component
  localparam int QP_W       = 2 * QC_W;
  localparam int SCR_W      = 32;   // screen coordinate

  // Rotation stage widths
  localparam int ROT_FRAC   = 28;
  localparam int MW         = 34;   // rotation matrix entry, Q28
  localparam int LO_W       = 24;   // low split of the difference vector
  localparam int PP_W       = MW + LO_W + 1;
  localparam int PS_W       = PP_W + 2;
  localparam int FULL_W     = PS_W + LO_W + 1;
  localparam int RW         = 58;   // rotated coordinate

  // Projection stage widths
  localparam int SCALE_FRAC = 16;
  localparam int RSPLIT     = 29;
  localparam int SP_W       = RSPLIT + 1 + SCR_W + 1 + 1;  // scale partial product
  localparam int HP_W       = RSPLIT + 1 + 17;             // half-size partial product
  localparam int PX_W       = SP_W + RSPLIT;
  localparam int ZW_W       = HP_W + RSPLIT;
  localparam int NW         = PX_W + 1;                    // signed numerator
  localparam int MAGW       = NW - 1;                      // numerator magnitude
  localparam int DENW       = RW - 1 + SCALE_FRAC;         // rz * 2^16

  // Divider
  localparam int QBITS      = SCR_W + 1;
  localparam int DIV_STAGES = QBITS + 1;
  localparam int DIVW       = DENW + QBITS + 1;

  localparam int MIN_DEPTH_DEF = 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_H = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_V = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALVES  = 3'd6;

  // Divider result
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QBITS-1:0] q;
  } div_res_t;

endpackage

// ===== hw/rtl/ppts_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, overflow check first.
module ppts_div import ppts_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [MAGW-1:0] num,
  input  logic [DENW-1:0] den,
  input  logic            neg,
  output div_res_t        res
);

  logic [DIVW-1:0]  rem  [QBITS];
  logic [DENW-1:0]  dn   [QBITS];
  logic [QBITS-1:0] qv   [DIV_STAGES];
  logic             ngv  [DIV_STAGES];
  logic             ovfv [DIV_STAGES];

  // Overflow check: quotient would need more than QBITS bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DIVW'(num);
      dn[0]   <= den;
      qv[0]   <= '0;
      ngv[0]  <= neg;
      ovfv[0] <= DIVW'(num) >= (DIVW'(den) << QBITS);
    end
  end

  // One quotient bit per stage, msb first
  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    localparam int BIT = QBITS - k;
    logic [DIVW-1:0] dsh;
    logic            ge;
    assign dsh = DIVW'(dn[k-1]) << BIT;
    assign ge  = rem[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        qv[k]   <= qv[k-1] | (QBITS'(ge) << BIT);
        ngv[k]  <= ngv[k-1];
        ovfv[k] <= ovfv[k-1];
      end
    end

    if (k < QBITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? rem[k-1] - dsh : rem[k-1];
          dn[k]  <= dn[k-1];
        end
      end
    end
  end

  assign res.neg = ngv[DIV_STAGES-1];
  assign res.ovf = ovfv[DIV_STAGES-1];
  assign res.q   = qv[DIV_STAGES-1];

endmodule

// ===== hw/rtl/project_point_to_screen.sv =====
// Perspective projection of world points through a quaternion camera.
//
// Input stream (s_t*): one world point per transfer, x, y, z in 48-bit
// signed fixed point. Output stream (m_t*): one screen point per input,
// 32-bit signed column and row, truncated toward zero and saturated;
// m_tuser flags a point whose depth lies below the minimum (row and
// column are then zero).
// Configuration channel (cfg_*): register index and 64-bit data; a
// transfer writes camera position, orientation, scales or viewport halves.
// Write only while no point is in flight. Index 7 is ignored.
// Throughput is one point per cycle while the receiver accepts results.
// The pipeline is 9 arithmetic stages (difference and quaternion
// products, matrix, split multiplies, sums, projection multiplies), then a
// 34-stage restoring divider (an overflow check, then one quotient bit per
// stage), then the saturating output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; s_tready is also low during a configuration transfer.
// Synchronous reset empties the pipeline and loads the register defaults.
module project_point_to_screen import ppts_pkg::*; #(
  parameter int MIN_DEPTH = MIN_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [143:0]         s_tdata,   // point_x, point_y, point_z
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // screen_x, screen_y
  output logic                 m_tuser,   // behind_camera
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int NSTG = 9 + DIV_STAGES + 1;
  localparam logic signed [MW-1:0] ROT_ONE =
    {{(MW-ROT_FRAC-1){1'b0}}, 1'b1, {ROT_FRAC{1'b0}}};

  // Configuration registers
  logic signed [POS_W-1:0] cam [3];
  logic [63:0]             quat;
  logic [31:0]             scale_h, scale_v, halves;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam[0]  <= '0;
      cam[1]  <= '0;
      cam[2]  <= '0;
      quat    <= 64'd16384;
      scale_h <= 32'h0001_0000;
      scale_v <= 32'h0001_0000;
      halves  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAM_X:   cam[0]  <= cfg_data[POS_W-1:0];
        CFG_CAM_Y:   cam[1]  <= cfg_data[POS_W-1:0];
        CFG_CAM_Z:   cam[2]  <= cfg_data[POS_W-1:0];
        CFG_QUAT:    quat    <= cfg_data;
        CFG_SCALE_H: scale_h <= cfg_data[31:0];
        CFG_SCALE_V: scale_v <= cfg_data[31:0];
        CFG_HALVES:  halves  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: whole pipe advances unless a result is stuck
  logic            en;
  logic [NSTG-1:0] vld;

  assign en       = ~vld[NSTG-1] | m_tready;
  assign s_tready = en & ~cfg_valid;
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_tvalid & s_tready};
    end
  end

  // Stage 1: difference vector and quaternion products
  logic signed [POS_W-1:0] pin [3];
  logic signed [QC_W-1:0]  qw, qx, qy, qz;
  logic signed [DIFF_W-1:0] d1 [3];
  logic signed [QP_W-1:0]  xx, yy, zz, xy, wz, xz, wy, yz, wx;

  assign pin[0] = s_tdata[47:0];
  assign pin[1] = s_tdata[95:48];
  assign pin[2] = s_tdata[143:96];
  assign qw     = quat[15:0];
  assign qz     = quat[31:16];
  assign qy     = quat[47:32];
  assign qx     = quat[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        d1[c] <= DIFF_W'(pin[c]) - DIFF_W'(cam[c]);
      end
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      xy <= qx * qy;
      wz <= qw * qz;
      xz <= qx * qz;
      wy <= qw * qy;
      yz <= qy * qz;
      wx <= qw * qx;
    end
  end

  // Stage 2: transposed rotation matrix, row r gives rotated coordinate r
  logic signed [MW-1:0]     tm [3][3];
  logic signed [DIFF_W-1:0] d2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      d2 <= d1;
      tm[0][0] <= ROT_ONE - ((MW'(yy) + MW'(zz)) <<< 1);
      tm[0][1] <= (MW'(xy) + MW'(wz)) <<< 1;
      tm[0][2] <= (MW'(xz) - MW'(wy)) <<< 1;
      tm[1][0] <= (MW'(xy) - MW'(wz)) <<< 1;
      tm[1][1] <= ROT_ONE - ((MW'(xx) + MW'(zz)) <<< 1);
      tm[1][2] <= (MW'(yz) + MW'(wx)) <<< 1;
      tm[2][0] <= (MW'(xz) + MW'(wy)) <<< 1;
      tm[2][1] <= (MW'(yz) - MW'(wx)) <<< 1;
      tm[2][2] <= ROT_ONE - ((MW'(xx) + MW'(yy)) <<< 1);
    end
  end

  // Stage 3: matrix times difference, split into low and high partials
  logic signed [PP_W-1:0] plo [3][3];
  logic signed [PP_W-1:0] phi [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          plo[r][c] <= tm[r][c] * $signed({1'b0, d2[c][LO_W-1:0]});
          phi[r][c] <= tm[r][c] * $signed(d2[c][DIFF_W-1:LO_W]);
        end
      end
    end
  end

  // Stage 4: sum partials of each row
  logic signed [PS_W-1:0] slo [3];
  logic signed [PS_W-1:0] shi [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        slo[r] <= PS_W'(plo[r][0]) + PS_W'(plo[r][1]) + PS_W'(plo[r][2]);
        shi[r] <= PS_W'(phi[r][0]) + PS_W'(phi[r][1]) + PS_W'(phi[r][2]);
      end
    end
  end

  // Stage 5: merge halves and drop the Q28 fraction (floor)
  logic signed [FULL_W-1:0] full [3];
  logic signed [RW-1:0]     r5 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      full[r] = (FULL_W'(shi[r]) <<< LO_W) + FULL_W'(slo[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        r5[r] <= RW'(full[r] >>> ROT_FRAC);
      end
    end
  end

  // Stage 6: depth test and projection partial products
  logic signed [RSPLIT:0]   rxl, ryl, rzl;
  logic signed [RW-RSPLIT-1:0] rxh, ryh, rzh;
  logic signed [SCR_W:0]    shs, svs;
  logic signed [16:0]       hws, hhs;
  logic signed [SP_W-1:0]   xl6, xh6, yl6, yh6;
  logic signed [HP_W-1:0]   wl6, wh6, hl6, hh6;
  logic [DENW-1:0]          den6, den7, den8, den9;
  logic                     bh6, bh7, bh8, bh9;

  assign rxl = $signed({1'b0, r5[0][RSPLIT-1:0]});
  assign ryl = $signed({1'b0, r5[1][RSPLIT-1:0]});
  assign rzl = $signed({1'b0, r5[2][RSPLIT-1:0]});
  assign rxh = $signed(r5[0][RW-1:RSPLIT]);
  assign ryh = $signed(r5[1][RW-1:RSPLIT]);
  assign rzh = $signed(r5[2][RW-1:RSPLIT]);
  assign shs = $signed({1'b0, scale_h});
  assign svs = $signed({1'b0, scale_v});
  assign hws = $signed({1'b0, halves[15:0]});
  assign hhs = $signed({1'b0, halves[31:16]});

  always_ff @(posedge clk) begin
    if (en) begin
      bh6  <= r5[2] < $signed(RW'(MIN_DEPTH));
      den6 <= {r5[2][DENW-SCALE_FRAC-1:0], {SCALE_FRAC{1'b0}}};
      xl6  <= rxl * shs;
      xh6  <= rxh * shs;
      yl6  <= ryl * svs;
      yh6  <= ryh * svs;
      wl6  <= rzl * hws;
      wh6  <= rzh * hws;
      hl6  <= rzl * hhs;
      hh6  <= rzh * hhs;
    end
  end

  // Stage 7: merge split products
  logic signed [PX_W-1:0] px7, py7;
  logic signed [ZW_W-1:0] pw7, ph7;

  always_ff @(posedge clk) begin
    if (en) begin
      bh7  <= bh6;
      den7 <= den6;
      px7  <= (PX_W'(xh6) <<< RSPLIT) + PX_W'(xl6);
      py7  <= (PX_W'(yh6) <<< RSPLIT) + PX_W'(yl6);
      pw7  <= (ZW_W'(wh6) <<< RSPLIT) + ZW_W'(wl6);
      ph7  <= (ZW_W'(hh6) <<< RSPLIT) + ZW_W'(hl6);
    end
  end

  // Stage 8: numerators, viewport offset folded in over the same denominator
  logic signed [NW-1:0] nx8, ny8;

  always_ff @(posedge clk) begin
    if (en) begin
      bh8  <= bh7;
      den8 <= den7;
      nx8  <= NW'(px7) + (NW'(pw7) <<< SCALE_FRAC);
      ny8  <= (NW'(ph7) <<< SCALE_FRAC) - NW'(py7);
    end
  end

  // Stage 9: sign and magnitude
  logic [MAGW-1:0] mx9, my9;
  logic            nx9, ny9;

  always_ff @(posedge clk) begin
    if (en) begin
      bh9  <= bh8;
      den9 <= den8;
      nx9  <= nx8[NW-1];
      ny9  <= ny8[NW-1];
      mx9  <= MAGW'(nx8[NW-1] ? -nx8 : nx8);
      my9  <= MAGW'(ny8[NW-1] ? -ny8 : ny8);
    end
  end

  // Dividers, one per coordinate
  div_res_t resx, resy;

  ppts_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (mx9),
    .den (den9),
    .neg (nx9),
    .res (resx)
  );

  ppts_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (my9),
    .den (den9),
    .neg (ny9),
    .res (resy)
  );

  // Behind flag rides alongside the dividers
  logic [DIV_STAGES-1:0] bh_dly;

  always_ff @(posedge clk) begin
    if (en) begin
      bh_dly <= {bh_dly[DIV_STAGES-2:0], bh9};
    end
  end

  // Apply sign and clamp to the 32-bit range
  function automatic logic [SCR_W-1:0] sat_res(input div_res_t r);
    logic [SCR_W-1:0] v;
    if (r.neg) begin
      if (r.ovf || r.q > {1'b0, 1'b1, {(SCR_W-1){1'b0}}}) begin
        v = {1'b1, {(SCR_W-1){1'b0}}};
      end else begin
        v = -r.q[SCR_W-1:0];
      end
    end else begin
      if (r.ovf || r.q > {2'b00, {(SCR_W-1){1'b1}}}) begin
        v = {1'b0, {(SCR_W-1){1'b1}}};
      end else begin
        v = r.q[SCR_W-1:0];
      end
    end
    return v;
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= bh_dly[DIV_STAGES-1];
      m_tdata <= bh_dly[DIV_STAGES-1] ? '0 : {sat_res(resy), sat_res(resx)};
    end
  end

endmodule

// ===== hw/rtl/ppts_chk.sv =====
// Port-level checks for the point projection block, bound to the top level.
module ppts_chk import ppts_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [63:0]          m_tdata,
  input logic                 m_tuser,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A point behind the camera reports a zero screen position
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("behind-camera result with nonzero coordinates");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // No point transfer in the same cycle as a register write
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !s_tready)
    else $error("point accepted during a configuration transfer");

endmodule

bind project_point_to_screen ppts_chk u_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the point-to-screen projection pipeline.
module tb_top;
  import ppts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [31:0] col;
    logic signed [31:0] row;
    logic               behind;
  } screen_pt_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [143:0]         s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [63:0]          m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  // Camera registers as seen by the predictor
  longint      cam_x, cam_y, cam_z;
  logic [63:0] orient;
  logic [31:0] scale_h, scale_v, halves;

  logic [143:0] pending_pts[$];
  screen_pt_t   expected_pts[$];
  int           errors = 0;
  bit           src_pause = 1'b1;
  bit           quiet = 1'b0;
  int           src_gap = 0;
  int           sink_gap = 0;
  logic         hold_start = 1'b0;
  int           hold_left = 0;

  project_point_to_screen dut (.*);

  always #10 clk = ~clk;

  // Camera transform, perspective divide, truncate and saturate
  function automatic screen_pt_t project_point(logic [143:0] pt);
    longint qw, qz, qy, qx, one;
    longint mtx[9];
    logic signed [127:0] d[3];
    logic signed [127:0] acc, rz, num_x, num_y, den, q, hw, hh, sh, sv;
    longint rot[3];
    screen_pt_t res;
    qw = $signed(orient[15:0]);
    qz = $signed(orient[31:16]);
    qy = $signed(orient[47:32]);
    qx = $signed(orient[63:48]);
    one = 64'sd1 <<< 28;
    mtx[0] = one - 2 * (qy * qy + qz * qz);
    mtx[1] = 2 * (qx * qy - qw * qz);
    mtx[2] = 2 * (qx * qz + qw * qy);
    mtx[3] = 2 * (qx * qy + qw * qz);
    mtx[4] = one - 2 * (qx * qx + qz * qz);
    mtx[5] = 2 * (qy * qz - qw * qx);
    mtx[6] = 2 * (qx * qz - qw * qy);
    mtx[7] = 2 * (qy * qz + qw * qx);
    mtx[8] = one - 2 * (qx * qx + qy * qy);
    d[0] = $signed(pt[47:0]);
    d[1] = $signed(pt[95:48]);
    d[2] = $signed(pt[143:96]);
    d[0] = d[0] - cam_x;
    d[1] = d[1] - cam_y;
    d[2] = d[2] - cam_z;
    // rotate by the conjugate: columns of the matrix
    for (int c = 0; c < 3; c++) begin
      acc = 128'(mtx[c]) * d[0] + 128'(mtx[c+3]) * d[1] + 128'(mtx[c+6]) * d[2];
      acc = acc >>> 28;
      rot[c] = acc[63:0];
    end
    res = '0;
    if (rot[2] < MIN_DEPTH_DEF) begin
      res.behind = 1'b1;
      return res;
    end
    rz = rot[2];
    hw = {112'b0, halves[15:0]};
    hh = {112'b0, halves[31:16]};
    sh = {96'b0, scale_h};
    sv = {96'b0, scale_v};
    den = rz <<< 16;
    num_x = 128'(rot[0]) * sh + rz * (hw <<< 16);
    num_y = rz * (hh <<< 16) - 128'(rot[1]) * sv;
    q = num_x / den;
    res.col = (q > 128'sd2147483647) ? 32'h7FFFFFFF :
              (q < -128'sd2147483648) ? 32'h80000000 : q[31:0];
    q = num_y / den;
    res.row = (q > 128'sd2147483647) ? 32'h7FFFFFFF :
              (q < -128'sd2147483648) ? 32'h80000000 : q[31:0];
    return res;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Point source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_pts.push_back(project_point(pending_pts.pop_front()));
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_pts.size() > 0 && !src_pause) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_pts[0];
        if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 7);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Result sink and checker
  always @(posedge clk) begin
    screen_pt_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pts.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d behind=%0b", $time,
                 $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tuser);
        errors++;
      end else begin
        want = expected_pts.pop_front();
        if (m_tdata[31:0] !== want.col) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, want.col,
                   $signed(m_tdata[31:0]));
          errors++;
        end
        if (m_tdata[63:32] !== want.row) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, want.row,
                   $signed(m_tdata[63:32]));
          errors++;
        end
        if (m_tuser !== want.behind) begin
          $display("%0t: behind_camera expected %0b actual %0b", $time, want.behind,
                   m_tuser);
          errors++;
        end
      end
    end
    if (rst || hold_left > 1) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 7);
    end
  end

  // One register write; predictor copy updated on the transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CAM_X:   cam_x = $signed(val[47:0]);
      CFG_CAM_Y:   cam_y = $signed(val[47:0]);
      CFG_CAM_Z:   cam_z = $signed(val[47:0]);
      CFG_QUAT:    orient = val;
      CFG_SCALE_H: scale_h = val[31:0];
      CFG_SCALE_V: scale_v = val[31:0];
      CFG_HALVES:  halves = val[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [47:0] cx, cy, cz, input logic [63:0] q,
                           input logic [31:0] sh, sv, hv);
    write_reg(CFG_CAM_X, {16'($urandom_range(0, 65535)), cx});
    write_reg(CFG_CAM_Y, {16'h0, cy});
    write_reg(CFG_CAM_Z, {16'hFFFF, cz});
    write_reg(CFG_QUAT, q);
    write_reg(CFG_SCALE_H, {$urandom, sh});
    write_reg(CFG_SCALE_V, {32'h0, sv});
    write_reg(CFG_HALVES, {32'hFFFFFFFF, hv});
  endtask

  // Release queued points and wait until every result is back
  task automatic run_batch();
    @(posedge clk);
    src_pause = 1'b0;
    wait (pending_pts.size() == 0 && expected_pts.size() == 0);
    src_pause = 1'b1;
    repeat (2) @(posedge clk);
  endtask

  // Points spread around the camera: mostly near, some anywhere
  task automatic queue_random(input int count, input int reach);
    logic [47:0] px, py, pz;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        px = 48'(cam_x + ($signed($urandom) >>> (32 - reach)));
        py = 48'(cam_y + ($signed($urandom) >>> (32 - reach)));
        pz = 48'(cam_z + ($signed($urandom) >>> (32 - reach)));
      end else begin
        px = rand48();
        py = rand48();
        pz = rand48();
      end
      pending_pts.push_back({pz, py, px});
    end
  endtask

  localparam logic [47:0] P_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] P_MIN = 48'h8000_0000_0000;
  localparam logic [47:0] P_ONE = 48'h0000_0001_0000;

  initial begin
    cam_x = 0; cam_y = 0; cam_z = 0;
    orient = 64'd16384;
    scale_h = 32'd65536; scale_v = 32'd65536; halves = 32'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed points against reset defaults
    pending_pts.push_back({48'd0, 48'd0, 48'd0});
    pending_pts.push_back({48'd1, 48'd0, 48'd0});
    pending_pts.push_back({48'hFFFF_FFFF_FFFF, 48'd5, 48'd5});
    pending_pts.push_back({48'd1, P_MAX, P_MAX});
    pending_pts.push_back({48'd1, P_MIN, P_MIN});
    pending_pts.push_back({P_MAX, P_MAX, P_MIN});
    pending_pts.push_back({P_MIN, P_MIN, P_MAX});
    pending_pts.push_back({P_ONE, P_ONE, P_ONE});
    pending_pts.push_back({P_ONE, 48'hFFFF_FFFF_0000, 48'd3 * P_ONE});
    pending_pts.push_back({48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF});
    pending_pts.push_back({48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555});
    run_batch();

    // Typical camera: identity, screen center 640x360
    write_all(48'd0, 48'd0, 48'd0, 64'd16384, 32'd640 << 16, 32'd640 << 16,
              {16'd360, 16'd640});
    write_reg(CFG_UNUSED, 64'hDEAD_BEEF_0000_0001);
    pending_pts.push_back({P_ONE, 48'd0, 48'd0});
    pending_pts.push_back({48'd1, P_ONE, P_ONE});
    pending_pts.push_back({P_ONE, 48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000});
    queue_random(100, 24);
    run_batch();

    // Rotated and offset camera; receiver holds off while the source keeps going
    write_all(48'h0000_0010_0000, 48'hFFFF_FFF0_0000, 48'h0000_0003_8000,
              {16'd11585, 16'd0, 16'd0, 16'd11585}, 32'h0100_0000, 32'h00C0_0000,
              {16'd540, 16'd960});
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    queue_random(100, 26);
    run_batch();

    // Extremes: non-unit quaternions, far cameras, full-scale then near-zero registers
    write_all(P_MAX, P_MIN, P_MAX, 64'h8000_7FFF_FFFF_8000, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(60, 31);
    run_batch();
    write_all(P_MIN, P_MAX, P_MIN, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd1, 32'd0);
    queue_random(40, 31);
    run_batch();

    // Random cameras, last one without idling
    for (int ph = 0; ph < 4; ph++) begin
      write_all(rand48() >>> 8, rand48() >>> 8, rand48() >>> 8,
                {$urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4096)),
                 16'($urandom), 16'($urandom_range(0, 8192)), 16'($urandom_range(8192, 16384))},
                $urandom, $urandom_range(0, 32'h0400_0000), $urandom);
      if (ph == 3) quiet = 1'b1;
      queue_random(50, $urandom_range(20, 30));
      run_batch();
    end

    repeat (60) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
